// File: hdl/rdlc_pkg.sv
// Shared types, constants and helpers for the range distinct letter counter.
`timescale 1ns / 1ps

package rdlc_pkg;

  // Store size and alphabet.
  localparam int MAX_LEN  = 1024;
  localparam int ALPHABET = 26;

  // Fixed field widths of the item ports.
  localparam int POS_W    = 10;
  localparam int LETTER_W = 5;
  localparam int COUNT_W  = 5;

  // Tree node addresses: leaves sit at MAX_LEN .. 2*MAX_LEN-1.
  localparam int NODE_W   = $clog2(MAX_LEN) + 1;
  localparam int PTR_W    = NODE_W + 1;
  localparam int NODE_CNT = 2 * MAX_LEN;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [ALPHABET-1:0] mask_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEAF,
    ST_UPD_UP,
    ST_Q_A,
    ST_Q_B,
    ST_Q_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_step;
    logic upd_leaf;
    logic upd_up;
    logic q_a;
    logic q_b;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic wr_ok;
    logic root_next;
    logic a_lt_b;
  } status_t;

  // Number of set bits in a letter mask.
  function automatic count_t mask_popcount(input mask_t m);
    count_t cnt;
    cnt = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      cnt = cnt + count_t'(m[i]);
    end
    return cnt;
  endfunction

endpackage

// File: hdl/rdlc_ctrl.sv
// Controller state machine of the range distinct letter counter.
`timescale 1ns / 1ps

module rdlc_ctrl
  import rdlc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_mode,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (in_mode) begin
            state_nxt = ST_Q_A;
          end else if (status.wr_ok) begin
            state_nxt = ST_UPD_LEAF;
          end
        end
      end
      ST_UPD_LEAF: begin
        state_nxt = ST_UPD_UP;
      end
      ST_UPD_UP: begin
        if (status.root_next) state_nxt = ST_IDLE;
      end
      ST_Q_A: begin
        state_nxt = status.a_lt_b ? ST_Q_B : ST_Q_FIN;
      end
      ST_Q_B: begin
        state_nxt = ST_Q_A;
      end
      ST_Q_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_UPD_LEAF: begin
        cmd.upd_leaf = 1'b1;
      end
      ST_UPD_UP: begin
        cmd.upd_up = 1'b1;
      end
      ST_Q_A: begin
        cmd.q_a = status.a_lt_b;
      end
      ST_Q_B: begin
        cmd.q_b = 1'b1;
      end
      ST_Q_FIN: begin
        cmd.fin = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // The clearing pass never overlaps item work.
  a_clr_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !(cmd.load || cmd.upd_leaf || cmd.upd_up || cmd.q_a || cmd.fin))
    else $error("clear step overlaps item work");

  // The right boundary step always follows a left boundary step.
  a_qb_after_qa: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_b |-> $past(cmd.q_a))
    else $error("right boundary step without left step");

  // Climbing the tree always starts from a leaf write.
  a_up_after_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cmd.upd_up) |-> $past(cmd.upd_leaf))
    else $error("tree climb without leaf write");

endmodule

// File: hdl/rdlc_dp.sv
// Datapath of the range distinct letter counter: presence tree memory and walkers.
`timescale 1ns / 1ps

module rdlc_dp
  import rdlc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_mode,
  input  logic [POS_W-1:0]    in_position,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic [POS_W-1:0]    in_range_left,
  input  logic [POS_W-1:0]    in_range_right,
  input  cmd_t                cmd,
  output status_t             status,
  output logic                out_valid,
  output logic [COUNT_W-1:0]  out_distinct_count
);

  // Presence tree: each node holds the OR of the letter masks below it.
  mask_t tree_mem [NODE_CNT];

  node_t  node_r;
  mask_t  acc_r;
  ptr_t   a_r;
  ptr_t   b_r;
  mask_t  rd_data_r;
  logic   q_rd_vld_r;
  node_t  clr_addr_r;
  logic   out_valid_r;
  count_t count_r;

  logic [31:0] pos_ext;
  logic [31:0] left_ext;
  logic [31:0] right_c;
  logic        range_empty;
  node_t       leaf;
  mask_t       letter_mask;
  ptr_t        a_init;
  ptr_t        b_init;
  node_t       parent;
  ptr_t        b_dec;
  mask_t       parent_mask;

  logic  mem_we;
  node_t mem_waddr;
  mask_t mem_wdata;
  logic  mem_re;
  node_t mem_raddr;
  logic  q_rd;

  // Decode of the incoming item.
  always_comb begin
    pos_ext     = 32'(in_position);
    left_ext    = 32'(in_range_left);
    right_c     = (32'(in_range_right) > 32'(MAX_LEN - 1)) ? 32'(MAX_LEN - 1)
                                                            : 32'(in_range_right);
    range_empty = left_ext > right_c;
    leaf        = NODE_W'(pos_ext + 32'(MAX_LEN));
    letter_mask = mask_t'(1) << in_letter;
    b_init      = PTR_W'(right_c + 32'(MAX_LEN) + 32'd1);
    a_init      = range_empty ? b_init : PTR_W'(left_ext + 32'(MAX_LEN));
  end

  // Walker helpers.
  assign parent      = node_r >> 1;
  assign b_dec       = b_r - ptr_t'(1);
  assign parent_mask = acc_r | rd_data_r;

  // Status back to the controller.
  assign status.clr_last  = (clr_addr_r == node_t'(NODE_CNT - 1));
  assign status.wr_ok     = (pos_ext < 32'(MAX_LEN)) && (32'(in_letter) < 32'(ALPHABET));
  assign status.root_next = (parent == node_t'(1));
  assign status.a_lt_b    = a_r < b_r;

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = node_r;
    q_rd      = 1'b0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.upd_leaf) begin
      mem_we    = 1'b1;
      mem_waddr = node_r;
      mem_wdata = acc_r;
      mem_re    = 1'b1;
      mem_raddr = {node_r[NODE_W-1:1], ~node_r[0]};
    end else if (cmd.upd_up) begin
      mem_we    = 1'b1;
      mem_waddr = parent;
      mem_wdata = parent_mask;
      mem_re    = 1'b1;
      mem_raddr = {parent[NODE_W-1:1], ~parent[0]};
    end else if (cmd.q_a) begin
      mem_re    = a_r[0];
      q_rd      = a_r[0];
      mem_raddr = a_r[NODE_W-1:0];
    end else if (cmd.q_b) begin
      mem_re    = b_r[0];
      q_rd      = b_r[0];
      mem_raddr = b_dec[NODE_W-1:0];
    end
  end

  // Tree memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= tree_mem[mem_raddr];
    end
  end

  // Control registers of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      q_rd_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + node_t'(1);
      q_rd_vld_r  <= q_rd;
      out_valid_r <= cmd.fin;
    end
  end

  // Walker and accumulator registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_r <= leaf;
      acc_r  <= in_mode ? '0 : letter_mask;
      a_r    <= a_init;
      b_r    <= b_init;
    end else if (cmd.upd_up) begin
      node_r <= parent;
      acc_r  <= parent_mask;
    end else begin
      if (q_rd_vld_r) acc_r <= acc_r | rd_data_r;
      if (cmd.q_a && a_r[0]) a_r <= a_r + ptr_t'(1);
      if (cmd.q_b) begin
        a_r <= a_r >> 1;
        b_r <= (b_r[0] ? b_dec : b_r) >> 1;
      end
    end
    if (cmd.fin) count_r <= mask_popcount(acc_r);
  end

  assign out_valid          = out_valid_r;
  assign out_distinct_count = count_r;

  // The climb never starts above the root.
  a_up_below_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_up |-> (node_r > node_t'(1)))
    else $error("tree climb above root");

  // A result never counts more letters than the alphabet has.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_distinct_count) <= 32'(ALPHABET)))
    else $error("distinct count out of range");

  // Every result follows a finish command.
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.fin))
    else $error("result without finish");

endmodule

// File: hdl/range_distinct_letter_count_core.sv
// Top level of the range distinct letter counter: controller plus datapath.
`timescale 1ns / 1ps

// After reset the block clears every node of its presence tree, one node per
// cycle, with busy high. An item is taken when start is high and busy is low.
// A write item updates its leaf and then each parent up to the root, one per
// tree level, bounded by the single read and single write port of the tree
// memory; a write to an out-of-range position or with an out-of-alphabet
// letter is dropped. A query walks the two range edges up the tree, reading
// up to two nodes per level through the one read port. The count appears on
// out_distinct_count for one cycle with out_valid high; the receiver cannot
// stall the block, so the value must be captured then.
module range_distinct_letter_count_core
  import rdlc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_mode,
  input  logic [POS_W-1:0]    in_position,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic [POS_W-1:0]    in_range_left,
  input  logic [POS_W-1:0]    in_range_right,
  output logic                out_valid,
  output logic [COUNT_W-1:0]  out_distinct_count
);

  cmd_t    cmd;
  status_t status;

  // Sequencing of clear, update and query walks.
  rdlc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Tree memory, walkers and result register.
  rdlc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_mode),
    .in_position        (in_position),
    .in_letter          (in_letter),
    .in_range_left      (in_range_left),
    .in_range_right     (in_range_right),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_distinct_count (out_distinct_count)
  );

endmodule
